// ===== rtl/lruo_pkg.sv =====
// ----------------------------------------------------------------------------
// lruo_pkg
// Shared types, constants and the control store for the LRU order tracker.
// ----------------------------------------------------------------------------
package lruo_pkg;

  localparam int ENTRIES   = 1024;
  localparam int ID_W      = 10;
  localparam int CMD_W     = 2;
  localparam int ID_SPAN   = 1 << ID_W;
  localparam int MEM_DEPTH = (ENTRIES < ID_SPAN) ? ENTRIES : ID_SPAN;
  localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ACCESS = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic            has;
    logic [ID_W-1:0] id;
  } link_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_CHECK  = 3'd1,
    S_UNLINK = 3'd2,
    S_ATT_A  = 3'd3,
    S_ATT_B  = 3'd4,
    S_EMIT   = 3'd5
  } step_t;

  typedef enum logic [2:0] {
    J_GOTO      = 3'd0,
    J_WAIT_IN   = 3'd1,
    J_WAIT_OUT  = 3'd2,
    J_DISPATCH  = 3'd3,
    J_IF_ACCESS = 3'd4
  } jump_t;

  typedef struct packed {
    logic  take_in;
    logic  unlink;
    logic  attach_a;
    logic  attach_b;
    logic  emit;
    jump_t jump;
    step_t next_s;
    step_t br_a;
    step_t br_b;
  } uop_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic skip;
    logic is_insert;
    logic is_access;
  } seq_stat_t;

  function automatic uop_t ucode(step_t s);
    uop_t u;
    u = '{take_in: 1'b0, unlink: 1'b0, attach_a: 1'b0, attach_b: 1'b0, emit: 1'b0,
          jump: J_GOTO, next_s: S_IDLE, br_a: S_IDLE, br_b: S_IDLE};
    unique case (s)
      S_IDLE: begin
        u.take_in = 1'b1;
        u.jump    = J_WAIT_IN;
        u.next_s  = S_CHECK;
      end
      S_CHECK: begin
        u.jump   = J_DISPATCH;
        u.next_s = S_UNLINK;
        u.br_a   = S_ATT_A;
        u.br_b   = S_EMIT;
      end
      S_UNLINK: begin
        u.unlink = 1'b1;
        u.jump   = J_IF_ACCESS;
        u.next_s = S_EMIT;
        u.br_a   = S_ATT_A;
      end
      S_ATT_A: begin
        u.attach_a = 1'b1;
        u.next_s   = S_ATT_B;
      end
      S_ATT_B: begin
        u.attach_b = 1'b1;
        u.next_s   = S_EMIT;
      end
      S_EMIT: begin
        u.emit   = 1'b1;
        u.jump   = J_WAIT_OUT;
        u.next_s = S_IDLE;
      end
      default: begin
        u.next_s = S_IDLE;
      end
    endcase
    return u;
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(logic [ID_W-1:0] id);
    return id[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/lruo_ifs.sv =====
// ----------------------------------------------------------------------------
// lruo_ifs
// Request and response channels of the LRU order tracker.
// ----------------------------------------------------------------------------
interface lruo_req_if;
  import lruo_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0]  entry_id;

  modport source (output valid, command, entry_id, input ready);
  modport sink   (input valid, command, entry_id, output ready);
endinterface

interface lruo_rsp_if;
  import lruo_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] victim_id;
  logic            victim_valid;
  logic            bad_request;

  modport source (output valid, victim_id, victim_valid, bad_request, input ready);
  modport sink   (input valid, victim_id, victim_valid, bad_request, output ready);
endinterface

// ===== rtl/lru_order_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_order_tracker
// Recency order over resident ids as a doubly linked list in link memories;
// every request returns the least recently used id as the victim.
//
//   channel  dir  payload                                 handshake
//   req      in   command, entry_id                       valid / ready
//   rsp      out  victim_id, victim_valid, bad_request    valid / ready
//
// One request at a time, stepped by the control store: read, check, unlink,
// two attach steps on the single-port link memories, result load; a query
// or rejected one skips to the load, remove skips attach, insert skips unlink.
// After reset a clearing pass over all MEM_DEPTH (1024) entries zeroes the
// resident bits; req.ready stays low meanwhile.
// A held result in the output register does not block the next request;
// only the result load waits for the register to drain.
// ----------------------------------------------------------------------------
module lru_order_tracker (
  input logic     clk,
  input logic     rst,
  lruo_req_if.sink   req,
  lruo_rsp_if.source rsp
);
  import lruo_pkg::*;

  uop_t      ctrl;
  seq_stat_t stat;

  logic             clr_busy;
  logic [IDX_W-1:0] clr_addr;

  cmd_t            cur_cmd;
  logic [ID_W-1:0] cur_id;
  logic [ID_W-1:0] head_id;
  logic [ID_W-1:0] tail_id;
  logic            list_nonempty;

  logic resident_mem [MEM_DEPTH];
  link_t older_mem   [MEM_DEPTH];
  link_t newer_mem   [MEM_DEPTH];

  logic             res_q;
  link_t            older_q;
  link_t            newer_q;

  logic             res_we, res_re, res_wd;
  logic [IDX_W-1:0] res_addr;
  logic             old_we, old_re;
  logic [IDX_W-1:0] old_addr;
  link_t            old_wd;
  logic             new_we, new_re;
  logic [IDX_W-1:0] new_addr;
  link_t            new_wd;

  logic in_fire, out_free, in_range, bad;

  assign req.ready = ctrl.take_in && !clr_busy;
  assign in_fire   = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign in_range  = 32'(cur_id) < 32'(ENTRIES);

  always_comb begin
    unique case (cur_cmd)
      CMD_INSERT: bad = !in_range || res_q;
      CMD_ACCESS,
      CMD_REMOVE: bad = !in_range || !res_q;
      CMD_QUERY:  bad = 1'b0;
      default:    bad = 1'b0;
    endcase
  end

  assign stat.in_fire   = in_fire;
  assign stat.out_free  = out_free;
  assign stat.skip      = bad || (cur_cmd == CMD_QUERY);
  assign stat.is_insert = cur_cmd == CMD_INSERT;
  assign stat.is_access = cur_cmd == CMD_ACCESS;

  lruo_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // memory port steering
  always_comb begin
    res_we   = 1'b0;
    res_re   = 1'b0;
    res_wd   = 1'b0;
    res_addr = to_idx(cur_id);
    old_we   = 1'b0;
    old_re   = 1'b0;
    old_wd   = older_q;
    old_addr = to_idx(cur_id);
    new_we   = 1'b0;
    new_re   = 1'b0;
    new_wd   = newer_q;
    new_addr = to_idx(cur_id);
    priority if (clr_busy) begin
      res_we   = 1'b1;
      res_addr = clr_addr;
    end else if (in_fire) begin
      res_re   = 1'b1;
      old_re   = 1'b1;
      new_re   = 1'b1;
      res_addr = to_idx(req.entry_id);
      old_addr = to_idx(req.entry_id);
      new_addr = to_idx(req.entry_id);
    end else if (ctrl.unlink) begin
      res_we   = 1'b1;
      old_we   = newer_q.has;
      old_addr = to_idx(newer_q.id);
      old_wd   = older_q;
      new_we   = older_q.has;
      new_addr = to_idx(older_q.id);
      new_wd   = newer_q;
    end else if (ctrl.attach_a) begin
      res_we = 1'b1;
      res_wd = 1'b1;
      old_we = 1'b1;
      old_wd = '{has: list_nonempty, id: head_id};
      new_we = 1'b1;
      new_wd = '{has: 1'b0, id: '0};
    end else if (ctrl.attach_b) begin
      new_we   = list_nonempty;
      new_addr = to_idx(head_id);
      new_wd   = '{has: 1'b1, id: cur_id};
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) resident_mem[res_addr] <= res_wd;
    if (res_re) res_q <= resident_mem[res_addr];
  end

  always_ff @(posedge clk) begin
    if (old_we) older_mem[old_addr] <= old_wd;
    if (old_re) older_q <= older_mem[old_addr];
  end

  always_ff @(posedge clk) begin
    if (new_we) newer_mem[new_addr] <= new_wd;
    if (new_re) newer_q <= newer_mem[new_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(MEM_DEPTH - 1)) clr_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_cmd <= cmd_t'(req.command);
      cur_id  <= req.entry_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_id       <= '0;
      tail_id       <= '0;
      list_nonempty <= 1'b0;
    end else if (ctrl.unlink) begin
      if (!newer_q.has) head_id <= older_q.has ? older_q.id : '0;
      if (!older_q.has) tail_id <= newer_q.has ? newer_q.id : '0;
      if (!newer_q.has && !older_q.has) list_nonempty <= 1'b0;
    end else if (ctrl.attach_b) begin
      if (!list_nonempty) tail_id <= cur_id;
      head_id       <= cur_id;
      list_nonempty <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      rsp.victim_id    <= list_nonempty ? tail_id : '0;
      rsp.victim_valid <= list_nonempty;
      rsp.bad_request  <= bad;
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !req.ready)
    else $error("request taken during clearing pass");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    !list_nonempty |-> (head_id == '0 && tail_id == '0))
    else $error("empty list with nonzero head or tail");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ctrl.jump == J_DISPATCH)
    else $error("accepted request not followed by dispatch");

  a_bad_no_change: assert property (@(posedge clk) disable iff (rst)
    (ctrl.jump == J_DISPATCH && bad) |=>
      ($stable(head_id) && $stable(tail_id) && $stable(list_nonempty)))
    else $error("rejected request changed list state");

endmodule

// ===== rtl/lruo_seq.sv =====
// ----------------------------------------------------------------------------
// lruo_seq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module lruo_seq (
  input  logic              clk,
  input  logic              rst,
  input  lruo_pkg::seq_stat_t stat,
  output lruo_pkg::uop_t    ctrl
);
  import lruo_pkg::*;

  step_t step;
  step_t step_next;

  assign ctrl = ucode(step);

  always_comb begin
    step_next = step;
    unique case (ctrl.jump)
      J_GOTO:      step_next = ctrl.next_s;
      J_WAIT_IN:   step_next = stat.in_fire ? ctrl.next_s : step;
      J_WAIT_OUT:  step_next = stat.out_free ? ctrl.next_s : step;
      J_DISPATCH: begin
        priority if (stat.skip)      step_next = ctrl.br_b;
        else if (stat.is_insert)     step_next = ctrl.br_a;
        else                         step_next = ctrl.next_s;
      end
      J_IF_ACCESS: step_next = stat.is_access ? ctrl.br_a : ctrl.next_s;
      default:     step_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== tb/sv/tb_lru_order_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_order_tracker
// Drives insert, access, remove and query requests into the LRU order
// tracker and checks every victim against a local linked-list model of the
// recency order. A directed list covers the empty list, the id extremes,
// duplicates and absent ids, head, middle and tail moves. Random traffic
// with random gaps on both channels and one long response stall follows.
// ----------------------------------------------------------------------------
module tb_lru_order_tracker;
  import lruo_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int PHASE_LEN    = 50;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PLAN_LEN     = 23;

  typedef struct packed {
    logic [ID_W-1:0] victim_id;
    logic            victim_valid;
    logic            bad_request;
  } victim_t;

  typedef struct {
    cmd_t            cmd;
    logic [ID_W-1:0] id;
    bit              typed;
    victim_t         outcome;
  } plan_row_t;

  logic clk;
  logic rst;
  lruo_req_if req_ch ();
  lruo_rsp_if rsp_ch ();

  lru_order_tracker dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // recency order model
  logic [ID_W-1:0] older_of [ENTRIES];
  logic [ID_W-1:0] newer_of [ENTRIES];
  bit              has_older_of [ENTRIES];
  bit              has_newer_of [ENTRIES];
  bit              tracked [ENTRIES];
  logic [ID_W-1:0] mru_id = '0;
  logic [ID_W-1:0] lru_id = '0;
  bit              any_tracked = 1'b0;
  int              tracked_ids [$];

  victim_t pending_victims [$];
  int      errors = 0;
  int      cycle_count = 0;
  bit      steady = 1'b0;
  bit      hold_rsp = 1'b0;

  plan_row_t plan [PLAN_LEN] = '{
    '{CMD_QUERY,  10'd0,    1'b1, '{10'd0,    1'b0, 1'b0}},
    '{CMD_QUERY,  10'd1023, 1'b1, '{10'd0,    1'b0, 1'b0}},
    '{CMD_ACCESS, 10'd5,    1'b1, '{10'd0,    1'b0, 1'b1}},
    '{CMD_REMOVE, 10'd1023, 1'b1, '{10'd0,    1'b0, 1'b1}},
    '{CMD_INSERT, 10'd0,    1'b1, '{10'd0,    1'b1, 1'b0}},
    '{CMD_REMOVE, 10'd0,    1'b1, '{10'd0,    1'b0, 1'b0}},
    '{CMD_INSERT, 10'd1023, 1'b1, '{10'd1023, 1'b1, 1'b0}},
    '{CMD_INSERT, 10'd0,    1'b1, '{10'd1023, 1'b1, 1'b0}},
    '{CMD_INSERT, 10'd0,    1'b1, '{10'd1023, 1'b1, 1'b1}},
    '{CMD_ACCESS, 10'd1023, 1'b1, '{10'd0,    1'b1, 1'b0}},
    '{CMD_ACCESS, 10'd1023, 1'b1, '{10'd0,    1'b1, 1'b0}},
    '{CMD_INSERT, 10'd512,  1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_ACCESS, 10'd1023, 1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_REMOVE, 10'd512,  1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_INSERT, 10'd341,  1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_INSERT, 10'd682,  1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_REMOVE, 10'd0,    1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_REMOVE, 10'd682,  1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_ACCESS, 10'd0,    1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_QUERY,  10'd682,  1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_REMOVE, 10'd1023, 1'b0, '{10'd0,    1'b0, 1'b0}},
    '{CMD_REMOVE, 10'd341,  1'b1, '{10'd0,    1'b0, 1'b0}},
    '{CMD_QUERY,  10'd0,    1'b1, '{10'd0,    1'b0, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void place_at_front(int id);
    has_newer_of[id] = 1'b0;
    has_older_of[id] = any_tracked;
    older_of[id]     = mru_id;
    if (any_tracked) begin
      newer_of[mru_id]     = ID_W'(id);
      has_newer_of[mru_id] = 1'b1;
    end else begin
      lru_id = ID_W'(id);
    end
    mru_id      = ID_W'(id);
    any_tracked = 1'b1;
    tracked[id] = 1'b1;
    tracked_ids.push_back(id);
  endfunction

  function automatic void take_out(int id);
    logic [ID_W-1:0] nw;
    logic [ID_W-1:0] od;
    bit              hn;
    bit              ho;
    nw = newer_of[id];
    od = older_of[id];
    hn = has_newer_of[id];
    ho = has_older_of[id];
    if (hn) begin
      older_of[nw]     = od;
      has_older_of[nw] = ho;
    end else begin
      mru_id = ho ? od : '0;
    end
    if (ho) begin
      newer_of[od]     = nw;
      has_newer_of[od] = hn;
    end else begin
      lru_id = hn ? nw : '0;
    end
    if (!hn && !ho) begin
      any_tracked = 1'b0;
      mru_id      = '0;
      lru_id      = '0;
    end
    tracked[id] = 1'b0;
    foreach (tracked_ids[i]) begin
      if (tracked_ids[i] == id) begin
        tracked_ids.delete(i);
        break;
      end
    end
  endfunction

  function automatic victim_t track_request(cmd_t cmd, logic [ID_W-1:0] id);
    victim_t v;
    bit      legal;
    bit      bad;
    legal = int'(id) < ENTRIES;
    bad   = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (!legal || tracked[id]) bad = 1'b1;
        else place_at_front(int'(id));
      end
      CMD_ACCESS: begin
        if (!legal || !tracked[id]) begin
          bad = 1'b1;
        end else begin
          take_out(int'(id));
          place_at_front(int'(id));
        end
      end
      CMD_REMOVE: begin
        if (!legal || !tracked[id]) bad = 1'b1;
        else take_out(int'(id));
      end
      default: ;
    endcase
    v.victim_id    = any_tracked ? lru_id : '0;
    v.victim_valid = any_tracked;
    v.bad_request  = bad;
    return v;
  endfunction

  function automatic logic [ID_W-1:0] pick_absent();
    int id;
    do id = $urandom_range(0, ENTRIES - 1); while (tracked[id]);
    return ID_W'(id);
  endfunction

  function automatic logic [ID_W-1:0] pick_tracked();
    return ID_W'(tracked_ids[$urandom_range(0, tracked_ids.size() - 1)]);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic issue_request(cmd_t cmd, logic [ID_W-1:0] id, bit typed, victim_t outcome);
    int      gap;
    victim_t v;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= cmd;
    req_ch.entry_id <= id;
    do @(posedge clk); while (!req_ch.ready);
    v = track_request(cmd, id);
    pending_victims.push_back(typed ? outcome : v);
    @(negedge clk);
  endtask

  // response side
  initial begin
    int hold;
    bit long_done;
    long_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_rsp && !long_done) begin
        hold      = LONG_HOLD;
        long_done = 1'b1;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 5);
      end
      if (hold != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    victim_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_victims.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: victim_id=%0d victim_valid=%0b bad_request=%0b",
                   rsp_ch.victim_id, rsp_ch.victim_valid, rsp_ch.bad_request);
        errors++;
      end else begin
        want = pending_victims.pop_front();
        if (rsp_ch.victim_id !== want.victim_id || rsp_ch.victim_valid !== want.victim_valid ||
            rsp_ch.bad_request !== want.bad_request) begin
          if (errors < 10)
            $display("mismatch: victim_id %0d/%0d victim_valid %0b/%0b bad_request %0b/%0b (exp/act)",
                     want.victim_id, rsp_ch.victim_id, want.victim_valid, rsp_ch.victim_valid,
                     want.bad_request, rsp_ch.bad_request);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_order_tracker regression: fail");
      $finish;
    end
  end

  initial begin
    cmd_t            cmd;
    logic [ID_W-1:0] id;
    int              r;
    bit              grow;
    victim_t         none;
    none            = '0;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.command  = CMD_QUERY;
    req_ch.entry_id = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      issue_request(plan[i].cmd, plan[i].id, plan[i].typed, plan[i].outcome);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n / PHASE_LEN) % 3 == 2;
      grow   = (n / PHASE_LEN) % 2 == 0 && tracked_ids.size() < 300;
      if (n == 150) hold_rsp = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // malformed: duplicate insert or absent id
        case ($urandom_range(0, 2))
          0: begin
            if (tracked_ids.size() != 0) begin
              cmd = CMD_INSERT;
              id  = pick_tracked();
            end else begin
              cmd = CMD_ACCESS;
              id  = pick_absent();
            end
          end
          1: begin
            cmd = CMD_ACCESS;
            id  = pick_absent();
          end
          default: begin
            cmd = CMD_REMOVE;
            id  = pick_absent();
          end
        endcase
      end else if (r < 15) begin
        cmd = CMD_QUERY;
        id  = ID_W'($urandom_range(0, ENTRIES - 1));
      end else if (tracked_ids.size() == 0) begin
        cmd = CMD_INSERT;
        id  = pick_absent();
      end else begin
        r = $urandom_range(0, 99);
        if (r < (grow ? 55 : 15)) begin
          cmd = CMD_INSERT;
          id  = pick_absent();
        end else if (r < (grow ? 85 : 45)) begin
          cmd = CMD_ACCESS;
          id  = pick_tracked();
        end else begin
          cmd = CMD_REMOVE;
          id  = pick_tracked();
        end
      end
      issue_request(cmd, id, 1'b0, none);
    end
    req_ch.valid <= 1'b0;

    while (pending_victims.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_victims.size() == 0) begin
      $display("lru_order_tracker regression: pass");
    end else begin
      $display("lru_order_tracker regression: fail");
    end
    $finish;
  end

endmodule
